// ----- rtl/posting_list_skip_search_assert.svh -----
// Assertion macros shared by the RTL of the skip search block.
`ifndef POSTING_LIST_SKIP_SEARCH_ASSERT_SVH
`define POSTING_LIST_SKIP_SEARCH_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PSS_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("pss assertion failed");

// Next-cycle implication, checked out of reset.
`define PSS_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("pss assertion failed");

`endif

// ----- rtl/pss_pkg.sv -----
package pss_pkg;

  localparam int LIST_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(LIST_DEPTH);
  localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
  localparam int ID_W       = 32;

  localparam logic [ID_W-1:0] END_ID = '1;

  typedef enum logic [1:0] {
    KIND_LOAD      = 2'd0,
    KIND_SKIP_PAST = 2'd1,
    KIND_SKIP_TO   = 2'd2,
    KIND_NONE      = 2'd3
  } kind_t;

endpackage

// ----- rtl/pss_ram.sv -----
// Simple dual-port RAM, one write and one registered read per cycle.
module pss_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/posting_list_skip_search.sv -----
// Load request: taken while idle, busy stays low, no result.
// Skip request: result strobe (done) in the cycle after acceptance when the cursor is already
// at the end, else after the CHECK state and, unless the id at the cursor is already past the
// target, the binary search steps in SEARCH, one id store read per binary search step; busy is
// high until the result is shown. The receiver cannot stall: done, current_id and at_end are
// valid for one cycle only. Synchronous reset empties the list and zeroes the cursor; the id store keeps its contents.
module posting_list_skip_search (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                kind,
  input  logic [pss_pkg::ID_W-1:0]  entry_id,
  input  logic                      first_of_list,
  output logic                      done,
  output logic [pss_pkg::ID_W-1:0]  current_id,
  output logic                      at_end
);

`include "posting_list_skip_search_assert.svh"

  localparam int LEN_W  = pss_pkg::LEN_W;
  localparam int ADDR_W = pss_pkg::ADDR_W;
  localparam int ID_W   = pss_pkg::ID_W;

  // IDLE takes requests; CHECK compares the id at the cursor with the target;
  // SEARCH runs one halving step per cycle on the id read in the cycle before.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH
  } state_t;

  state_t             state;
  logic [LEN_W-1:0]   list_length;
  logic [LEN_W-1:0]   cursor;
  logic [LEN_W-1:0]   lo;
  logic [LEN_W-1:0]   hi;
  logic [LEN_W-1:0]   mid;
  logic [ID_W-1:0]    hi_val;    // id stored at hi, once hi has moved off the list end
  logic [ID_W-1:0]    target;
  logic               strict;    // skip past: stop at the first id strictly greater

  logic               accept;
  logic               is_load;
  logic               is_skip;
  logic               cursor_valid;
  logic               room;
  logic [ID_W-1:0]    rd_data;
  logic               go_right;
  logic               cur_greater;
  logic [LEN_W-1:0]   lo_next;
  logic [LEN_W-1:0]   hi_next;
  logic [LEN_W:0]     mid_sum;
  logic [LEN_W-1:0]   mid_next;
  logic [ID_W-1:0]    hi_val_next;
  logic               search_done;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;

  assign accept       = start && !busy;
  assign is_load      = (kind == pss_pkg::KIND_LOAD);
  assign is_skip      = (kind == pss_pkg::KIND_SKIP_PAST) || (kind == pss_pkg::KIND_SKIP_TO);
  assign cursor_valid = (cursor < list_length);
  assign room         = (list_length < LEN_W'(pss_pkg::LIST_DEPTH));

  // Compare the id read last cycle; the search direction follows the skip flavour.
  assign go_right    = strict ? (rd_data <= target) : (rd_data < target);
  assign cur_greater = (rd_data > target);

  // Next search bounds: CHECK seeds the range from the cursor to the list end,
  // SEARCH halves it.
  always_comb begin
    lo_next     = lo;
    hi_next     = hi;
    hi_val_next = hi_val;
    unique case (state)
      ST_CHECK: begin
        lo_next = cursor;
        hi_next = list_length;
      end
      ST_SEARCH: begin
        if (go_right) begin
          lo_next = mid + LEN_W'(1);
        end else begin
          hi_next     = mid;
          hi_val_next = rd_data;
        end
      end
      default: begin
      end
    endcase
  end

  assign mid_sum     = {1'b0, lo_next} + {1'b0, hi_next};
  assign mid_next    = mid_sum[LEN_W:1];
  assign search_done = !(lo_next < hi_next);

  // Read the cursor entry on acceptance, then the midpoint of each step.
  // Loads and skips are never in flight together, so a read never meets a
  // write to the same entry in one cycle and no forwarding is needed.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid_next[ADDR_W-1:0];
    unique case (state)
      ST_IDLE: begin
        rd_en   = accept && is_skip && cursor_valid;
        rd_addr = cursor[ADDR_W-1:0];
      end
      ST_CHECK:  rd_en = !cur_greater;
      ST_SEARCH: rd_en = !search_done;
      default: begin
      end
    endcase
  end

  // Append at the list end; a first-of-list load writes entry zero even when full.
  assign wr_en   = accept && is_load && (first_of_list || room);
  assign wr_addr = first_of_list ? '0 : list_length[ADDR_W-1:0];

  pss_ram #(
    .DEPTH  (pss_pkg::LIST_DEPTH),
    .DATA_W (ID_W),
    .ADDR_W (ADDR_W)
  ) u_id_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (entry_id),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      busy        <= 1'b0;
      done        <= 1'b0;
      list_length <= '0;
      cursor      <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (pss_pkg::kind_t'(kind))
              pss_pkg::KIND_LOAD: begin
                if (first_of_list) begin
                  list_length <= LEN_W'(1);
                  cursor      <= '0;
                end else if (room) begin
                  list_length <= list_length + LEN_W'(1);
                end
              end
              pss_pkg::KIND_SKIP_PAST, pss_pkg::KIND_SKIP_TO: begin
                target <= entry_id;
                strict <= (kind == pss_pkg::KIND_SKIP_PAST);
                if (cursor_valid) begin
                  state <= ST_CHECK;
                  busy  <= 1'b1;
                end else begin
                  // Cursor already at the end: the range is empty, report the end.
                  done       <= 1'b1;
                  current_id <= pss_pkg::END_ID;
                  at_end     <= 1'b1;
                end
              end
              default: begin
                // Unknown kind: drop the request.
              end
            endcase
          end
        end
        ST_CHECK: begin
          if (cur_greater) begin
            // Hold the cursor: its id is already past the target.
            state      <= ST_IDLE;
            busy       <= 1'b0;
            done       <= 1'b1;
            current_id <= rd_data;
            at_end     <= 1'b0;
          end else begin
            lo    <= lo_next;
            hi    <= hi_next;
            mid   <= mid_next;
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          lo     <= lo_next;
          hi     <= hi_next;
          mid    <= mid_next;
          hi_val <= hi_val_next;
          if (search_done) begin
            // The range has closed on hi; if hi never left the list end the
            // cursor is past the last entry, else its id is the one kept in hi_val.
            cursor     <= lo_next;
            state      <= ST_IDLE;
            busy       <= 1'b0;
            done       <= 1'b1;
            at_end     <= (hi_next == list_length);
            current_id <= (hi_next == list_length) ? pss_pkg::END_ID : hi_val_next;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  `PSS_ASSERT_NOW(a_len_bound, clk, rst, 1'b1, list_length <= LEN_W'(pss_pkg::LIST_DEPTH))
  `PSS_ASSERT_NOW(a_cursor_bound, clk, rst, 1'b1, cursor <= list_length)
  `PSS_ASSERT_NOW(a_end_id, clk, rst, done && at_end, current_id == pss_pkg::END_ID)
  `PSS_ASSERT_NEXT(a_skip_progress, clk, rst, accept && is_skip, busy || done)

endmodule
